>>> hdl/degenerate_triangle_filter_macros.svh
// Assertion macros for the checker file of the degenerate triangle filter.
`ifndef DEGENERATE_TRIANGLE_FILTER_MACROS_SVH
`define DEGENERATE_TRIANGLE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define DTF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define DTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/dtf_pkg.sv
// Types, constants and a helper function of the degenerate triangle filter.
package dtf_pkg;

  localparam int WIN_DEPTH = 10;
  localparam int WIN_AW    = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);

  localparam int COORD_W = 32;
  localparam int EDGE_W  = 33;
  localparam int SUM_W   = 34;
  localparam int DIFF_W  = 35;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 66;
  localparam int CROSS_W = 67;
  localparam int ACC_W   = 132;
  localparam int ROOT_W  = 44;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int TOTAL_W = 52;
  localparam int COUNT_W = 24;
  localparam int THR_W   = 32;

  localparam int IN_DATA_W  = 9 * COORD_W;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = ROOT_W + TOTAL_W + COUNT_W;
  localparam int OUT_USER_W = 3;
  localparam int CFG_AW     = 1;

  localparam logic [ROOT_W-1:0]  AREA_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [THR_W-1:0]   THR_RESET = THR_W'(10);

  typedef enum logic [CFG_AW-1:0] {
    REG_AREA_THR  = 1'b0,
    REG_CLOSE_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CROSS,
    ST_ROOT_GO,
    ST_WIN,
    ST_FIN
  } state_t;

  // Request to the square root unit.
  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } root_req_t;

  function automatic logic [OPND_W-1:0] abs_edge(input logic signed [EDGE_W-1:0] e);
    logic signed [EDGE_W-1:0] n;
    n = -e;
    return e[EDGE_W-1] ? n : e;
  endfunction

endpackage

>>> hdl/dtf_mul.sv
// Shared unsigned multiplier with a registered product.
module dtf_mul
  import dtf_pkg::*;
(
  input  logic              clk,
  input  logic [OPND_W-1:0] a,
  input  logic [OPND_W-1:0] b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> hdl/dtf_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module dtf_isqrt
  import dtf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  root_req_t         req,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 4;

  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [REM_W-1:0] rem2;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    rem2  = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    fits  = (rem2 >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && (cnt == '0)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt  <= CNT_W'(ROOT_W - 1);
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      cnt  <= cnt - 1'b1;
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= fits ? (rem2 - trial) : rem2;
      root <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

>>> hdl/degenerate_triangle_filter.sv
// Top level of the degenerate triangle filter: sequencer, window store and result register.
//
//  channel | signals                          | contents
//  --------+----------------------------------+-------------------------------------------
//  s_*     | s_tvalid s_tready s_tdata s_tuser | one triangle, first_of_mesh flag
//  m_*     | m_tvalid m_tready m_tdata m_tuser | keep/small/close flags, areas, kept count
//  cfg_*   | cfg_we cfg_addr cfg_wdata         | area and closeness thresholds
//
// A triangle passes from its input transfer through the cross product, the root start,
// the window comparison and the final step before m_tvalid rises, and the next triangle
// is taken only once the sequencer is idle again. The cross product terms run through
// the one shared 33x33 multiplier, the ST_ROOT_GO state starts the 44-step bit-serial
// square root that sets the length, and the ST_FIN state loads the result; the window
// comparison (four steps per stored face) runs beside the root and is always shorter.
// s_tready is high only while the sequencer is idle. A finished result sits in the
// output register, so the next triangle can be taken and worked on while the previous
// result waits; the sequencer stalls only in ST_FIN, on a busy root or a full register.
// Reset (rst, synchronous) empties the window, zeroes totals and restores both
// thresholds to 10.
module degenerate_triangle_filter
  import dtf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, 32 bits each from the lowest bit up
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // first_of_mesh
  input  logic [IN_USER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // face_area (44), total_area (52), kept_count (24) from the lowest bit up
  output logic [OUT_DATA_W-1:0] m_tdata,
  // keep, small_area, too_close from the lowest bit up
  output logic [OUT_USER_W-1:0] m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_AW-1:0]     cfg_addr,
  input  logic [THR_W-1:0]      cfg_wdata
);

  state_t state, state_next;

  logic [2:0]        cstep;
  logic [1:0]        cterm;
  logic [1:0]        wstep;
  logic [FILL_W-1:0] wk;

  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [SUM_W-1:0]  vsum [3];
  logic signed [SUM_W-1:0]  wsum [WIN_DEPTH][3];

  logic                      sab;
  logic                      scd;
  logic signed [CROSS_W-1:0] p1;
  logic [PROD_W-1:0]         xm;
  logic [ACC_W-1:0]          acc;
  logic [PROD_W-1:0]         dsum;
  logic                      wbad;
  logic                      close_acc;

  logic [FILL_W-1:0]  fill;
  logic [WIN_AW-1:0]  head;
  logic [TOTAL_W-1:0] area_total;
  logic [COUNT_W-1:0] kept_total;
  logic [THR_W-1:0]   area_thr;
  logic [THR_W-1:0]   close_thr;

  logic [OPND_W-1:0] mul_a;
  logic [OPND_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;
  root_req_t         root_req;
  logic              root_busy;
  logic [ROOT_W-1:0] root;

  // Input transfer
  logic in_xfer;
  assign in_xfer = s_tvalid && s_tready;

  // Cross product operand selection for the current term.
  logic signed [EDGE_W-1:0] ca, cb, cc, cd;
  always_comb begin
    case (cterm)
      2'd0: begin
        ca = e1[1]; cb = e2[2]; cc = e1[2]; cd = e2[1];
      end
      2'd1: begin
        ca = e1[2]; cb = e2[0]; cc = e1[0]; cd = e2[2];
      end
      default: begin
        ca = e1[0]; cb = e2[1]; cc = e1[1]; cd = e2[0];
      end
    endcase
  end

  // Signed second product and the magnitude of the cross term.
  logic signed [CROSS_W-1:0] p2;
  logic signed [CROSS_W-1:0] xdiff;
  logic signed [CROSS_W-1:0] xneg;
  always_comb begin
    p2    = scd ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    xdiff = p1 - p2;
    xneg  = -xdiff;
  end

  // Window distance for the current stored face and coordinate.
  logic signed [DIFF_W-1:0] wdiff;
  logic signed [DIFF_W-1:0] wneg;
  logic [DIFF_W-1:0]        wmag;
  logic                     wbig;
  logic                     wk_live;
  logic [PROD_W-1:0]        dtotal;
  logic                     near;
  always_comb begin
    wdiff = DIFF_W'(vsum[wstep]) - DIFF_W'(wsum[wk[WIN_AW-1:0]][wstep]);
    wneg  = -wdiff;
    wmag  = wdiff[DIFF_W-1] ? wneg : wdiff;
    // A coordinate distance of 2^32 or more can never be close.
    wbig    = (wmag[DIFF_W-1:COORD_W] != '0);
    wk_live = (wk < fill);
    dtotal  = dsum + prod;
    // A squared distance that leaves 64 bits is never close.
    near    = !wbad && (dtotal[PROD_W-1:64] == '0) && (dtotal[63:0] < 64'(close_thr));
  end

  // Final decision.
  logic               sat;
  logic [ROOT_W-1:0]  area;
  logic               area_low;
  logic               keep;
  logic               fin_go;
  logic [TOTAL_W:0]   total_sum;
  always_comb begin
    sat       = (acc[ACC_W-1:ACC_W-2] != '0);
    area      = sat ? AREA_MAX : root;
    area_low  = area < ROOT_W'(area_thr);
    keep      = !area_low && !close_acc;
    fin_go    = !root_busy && (!m_tvalid || m_tready);
    total_sum = {1'b0, area_total} + (TOTAL_W + 1)'(area);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_CROSS;
      ST_CROSS:   if ((cstep == 3'd6) && (cterm == 2'd2)) state_next = ST_ROOT_GO;
      ST_ROOT_GO: state_next = ST_WIN;
      ST_WIN:     if ((wstep == 2'd0) && !wk_live) state_next = ST_FIN;
      ST_FIN:     if (fin_go) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands and root start.
  always_comb begin
    s_tready          = 1'b0;
    mul_a             = '0;
    mul_b             = '0;
    root_req.start    = 1'b0;
    root_req.radicand = acc[ACC_W-3:42];
    case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_CROSS: begin
        case (cstep)
          3'd0: begin
            mul_a = abs_edge(ca); mul_b = abs_edge(cb);
          end
          3'd1: begin
            mul_a = abs_edge(cc); mul_b = abs_edge(cd);
          end
          3'd3: begin
            mul_a = xm[OPND_W-1:0]; mul_b = xm[OPND_W-1:0];
          end
          3'd4: begin
            mul_a = xm[OPND_W-1:0]; mul_b = xm[PROD_W-1:OPND_W];
          end
          3'd5: begin
            mul_a = xm[PROD_W-1:OPND_W]; mul_b = xm[PROD_W-1:OPND_W];
          end
          default: begin
            mul_a = '0; mul_b = '0;
          end
        endcase
      end
      ST_ROOT_GO: root_req.start = 1'b1;
      ST_WIN: begin
        if ((wstep != 2'd3) && wk_live && !wbig) begin
          mul_a = wmag[OPND_W-1:0];
          mul_b = wmag[OPND_W-1:0];
        end
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      area_thr  <= THR_RESET;
      close_thr <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_AREA_THR:  area_thr  <= cfg_wdata;
        REG_CLOSE_THR: close_thr <= cfg_wdata;
        default:       area_thr  <= area_thr;
      endcase
    end
  end

  // Result valid: set when a face finishes, cleared by the output transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_FIN) && fin_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Sequencer counters and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      cstep      <= '0;
      cterm      <= '0;
      wstep      <= '0;
      wk         <= '0;
      fill       <= '0;
      head       <= '0;
      area_total <= '0;
      kept_total <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          cstep <= '0;
          cterm <= '0;
          wstep <= '0;
          wk    <= '0;
          if (in_xfer && s_tuser[0]) begin
            fill       <= '0;
            head       <= '0;
            area_total <= '0;
            kept_total <= '0;
          end
        end
        ST_CROSS: begin
          if (cstep == 3'd6) begin
            cstep <= '0;
            cterm <= cterm + 1'b1;
          end else begin
            cstep <= cstep + 1'b1;
          end
        end
        ST_WIN: begin
          if (wstep == 2'd3) begin
            wstep <= '0;
            wk    <= wk + 1'b1;
          end else if (wk_live) begin
            wstep <= wstep + 1'b1;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            head     <= (head == WIN_AW'(WIN_DEPTH - 1)) ? '0 : head + 1'b1;
            if (fill != FILL_W'(WIN_DEPTH)) begin
              fill <= fill + 1'b1;
            end
            if (keep) begin
              if (kept_total != COUNT_MAX) begin
                kept_total <= kept_total + 1'b1;
              end
              // A face exactly at the threshold is kept but adds no area.
              if (area > ROOT_W'(area_thr)) begin
                area_total <= total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
              end
            end
          end
        end
        default: cstep <= cstep;
      endcase
    end
  end

  // Datapath registers; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          for (int i = 0; i < 3; i++) begin
            e1[i]   <= EDGE_W'($signed(s_tdata[(3 + i) * COORD_W +: COORD_W]))
                     - EDGE_W'($signed(s_tdata[i * COORD_W +: COORD_W]));
            e2[i]   <= EDGE_W'($signed(s_tdata[(6 + i) * COORD_W +: COORD_W]))
                     - EDGE_W'($signed(s_tdata[i * COORD_W +: COORD_W]));
            vsum[i] <= SUM_W'($signed(s_tdata[i * COORD_W +: COORD_W]))
                     + SUM_W'($signed(s_tdata[(3 + i) * COORD_W +: COORD_W]))
                     + SUM_W'($signed(s_tdata[(6 + i) * COORD_W +: COORD_W]));
          end
          acc       <= '0;
          close_acc <= 1'b0;
        end
      end
      ST_CROSS: begin
        case (cstep)
          3'd0: sab <= ca[EDGE_W-1] ^ cb[EDGE_W-1];
          3'd1: begin
            p1  <= sab ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
            scd <= cc[EDGE_W-1] ^ cd[EDGE_W-1];
          end
          3'd2: xm  <= xdiff[CROSS_W-1] ? xneg[PROD_W-1:0] : xdiff[PROD_W-1:0];
          3'd4: acc <= acc + ACC_W'(prod);
          3'd5: acc <= acc + (ACC_W'(prod) << 34);
          3'd6: acc <= acc + {prod, {PROD_W{1'b0}}};
          default: sab <= sab;
        endcase
      end
      ST_WIN: begin
        case (wstep)
          2'd0: wbad <= wbig;
          2'd1: begin
            wbad <= wbad | wbig;
            dsum <= prod;
          end
          2'd2: begin
            wbad <= wbad | wbig;
            dsum <= dtotal;
          end
          default: begin
            if (near) begin
              close_acc <= 1'b1;
            end
          end
        endcase
      end
      ST_FIN: begin
        if (fin_go) begin
          for (int i = 0; i < 3; i++) begin
            wsum[head][i] <= vsum[i];
          end
          m_tuser <= {close_acc, area_low, keep};
          m_tdata <= {(kept_total != COUNT_MAX && keep) ? kept_total + 1'b1 : kept_total,
                       (keep && (area > ROOT_W'(area_thr)))
                         ? (total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0])
                         : area_total,
                       area};
        end
      end
      default: sab <= sab;
    endcase
  end

  dtf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  dtf_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .req  (root_req),
    .busy (root_busy),
    .root (root)
  );

endmodule

>>> hdl/dtf_checker.sv
// Port-level assertions for the degenerate triangle filter and their binding.
`include "degenerate_triangle_filter_macros.svh"

module dtf_checker
  import dtf_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [OUT_USER_W-1:0] m_tuser
);

  // The block works on one triangle at a time.
  `DTF_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "ready after input transfer")

  // A face is kept exactly when neither test drops it.
  `DTF_ASSERT_SAME(a_keep_rule, m_tvalid, m_tuser[0] == (!m_tuser[1] && !m_tuser[2]), "keep flag mismatch")

  // A stalled result holds its contents.
  `DTF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind degenerate_triangle_filter dtf_checker u_dtf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
